// ----- design/twsa_pkg.sv -----
// package for the time window sample averager
// widths, defaults and controller state type; no dependencies
package twsa_pkg;

	localparam int DEPTH_DEF      = 1024;
	localparam logic [31:0] MAX_AGE_RESET = 32'd1000000;

	localparam int TIME_W  = 48;
	localparam int ELAP_W  = 32;
	localparam int SUM_W   = 42;
	localparam int CNT_W   = 10;
	localparam int MEAN_W  = 40;
	localparam int DIVN_W  = SUM_W + 8;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRITE,
		ST_RD_TAIL,
		ST_WAIT_TAIL,
		ST_CHECK,
		ST_RD_LAST,
		ST_WAIT_LAST,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic write;
		logic rd_tail;
		logic check;
		logic drop;
		logic force_drop;
		logic adv_head;
		logic rd_last;
		logic take_last;
		logic div_start;
		logic out_set;
	} cmd_t;

	typedef struct packed {
		logic is_query;
		logic empty;
		logic full_next;
		logic expired;
		logic div_done;
	} stat_t;

endpackage

// ----- design/twsa_ctrl.sv -----
// controller state machine for the time window sample averager
// uses twsa_pkg; drives twsa_dpath through cmd_t, watches stat_t
module twsa_ctrl import twsa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  logic  out_busy,
	input  stat_t st,
	output cmd_t  cmd
);

	state_t state_q, state_nx;
	logic   rec_cull_q, rec_cull_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rec_cull_q <= 1'b0;
		end else begin
			state_q    <= state_nx;
			rec_cull_q <= rec_cull_nx;
		end
	end

	always_comb begin
		state_nx    = state_q;
		rec_cull_nx = rec_cull_q;
		cmd         = '0;
		in_stall    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (st.is_query) begin
					state_nx    = ST_RD_TAIL;
					rec_cull_nx = 1'b0;
				end else begin
					cmd.write = 1'b1;
					if (st.full_next) begin
						state_nx    = ST_RD_TAIL;
						rec_cull_nx = 1'b1;
					end else begin
						cmd.adv_head = 1'b1;
						state_nx     = ST_RD_LAST;
					end
				end
			end
			ST_RD_TAIL: begin
				// all older samples culled; a record then just advances its head
				if (st.empty) begin
					if (rec_cull_q) begin
						cmd.adv_head = 1'b1;
					end
					state_nx = ST_RD_LAST;
				end else begin
					cmd.rd_tail = 1'b1;
					state_nx    = ST_WAIT_TAIL;
				end
			end
			ST_WAIT_TAIL: begin
				state_nx = ST_CHECK;
			end
			ST_CHECK: begin
				if (st.expired) begin
					cmd.drop = 1'b1;
					state_nx = ST_RD_TAIL;
				end else begin
					if (rec_cull_q) begin
						// still full after the cull: drop the oldest
						if (st.full_next) begin
							cmd.force_drop = 1'b1;
						end
						cmd.adv_head = 1'b1;
					end
					state_nx = ST_RD_LAST;
				end
			end
			ST_RD_LAST: begin
				cmd.rd_last = 1'b1;
				state_nx    = ST_WAIT_LAST;
			end
			ST_WAIT_LAST: begin
				cmd.take_last = 1'b1;
				cmd.div_start = 1'b1;
				state_nx      = ST_DIV;
			end
			ST_DIV: begin
				if (st.div_done) begin
					state_nx = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_busy) begin
					cmd.out_set = 1'b1;
					state_nx    = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

endmodule

// ----- design/twsa_dpath.sv -----
// datapath: sample ring memories, indexes, running sum, serial divider
// uses twsa_pkg; controlled by twsa_ctrl
module twsa_dpath import twsa_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output stat_t             st,
	input  logic              operation,
	input  logic [TIME_W-1:0] now_time,
	input  logic [TIME_W-1:0] start_time,
	input  logic [ELAP_W-1:0] elapsed,
	input  logic [31:0]       max_age_q,
	output logic [CNT_W-1:0]  cnt_o,
	output logic [SUM_W-1:0]  sum_o,
	output logic [ELAP_W-1:0] last_o,
	output logic [MEAN_W-1:0] mean_o,
	output logic              ovf_o
);

	localparam int AW = $clog2(DEPTH);
	localparam int QW = DIVN_W;
	localparam int IW = $clog2(QW + 1);

	logic [TIME_W-1:0] start_mem [DEPTH];
	logic [ELAP_W-1:0] elap_mem  [DEPTH];

	logic              op_q;
	logic [TIME_W-1:0] now_q, start_q;
	logic [ELAP_W-1:0] elap_q;
	logic [AW-1:0]     head_q, tail_q;
	logic [SUM_W-1:0]  sum_q;
	logic              ovf_q;
	logic [TIME_W-1:0] rd_start_q;
	logic [ELAP_W-1:0] rd_elap_q;
	logic [ELAP_W-1:0] last_q;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     head_nx, head_pm;
	logic [AW:0]       cnt_full;

	logic [QW-1:0]     num_q, quo_q;
	logic [AW:0]       den_q;
	logic [AW+1:0]     rem_q;
	logic [IW-1:0]     it_q;
	logic              div_busy_q;
	logic [AW+1:0]     rem_sh;
	logic              ge;

	function automatic logic [AW-1:0] inc(input logic [AW-1:0] i);
		logic [AW:0] s;
		s = {1'b0, i} + 1'b1;
		if (s == (AW+1)'(DEPTH)) begin
			return '0;
		end
		return s[AW-1:0];
	endfunction

	assign head_nx = inc(head_q);
	assign head_pm = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
	assign rd_addr = cmd.rd_last ? head_pm : tail_q;
	assign cnt_full = (head_q >= tail_q) ? {1'b0, head_q - tail_q}
		: (AW+1)'(DEPTH) - {1'b0, tail_q} + {1'b0, head_q};

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			start_mem[head_q] <= start_q;
			elap_mem[head_q]  <= elap_q;
		end
		rd_start_q <= start_mem[rd_addr];
		rd_elap_q  <= elap_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= operation;
			now_q   <= now_time;
			start_q <= start_time;
			elap_q  <= elapsed;
		end
		if (cmd.take_last) begin
			last_q <= rd_elap_q;
		end
	end

	// expiry of the sample read from the tail
	always_comb begin
		st.expired   = (now_q > rd_start_q) &&
			((now_q - rd_start_q) > {16'd0, max_age_q});
		st.is_query  = (op_q == OP_QUERY);
		st.empty     = (head_q == tail_q);
		st.full_next = (head_nx == tail_q);
		st.div_done  = !div_busy_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			sum_q  <= '0;
			ovf_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				ovf_q <= 1'b0;
			end
			if (cmd.write) begin
				sum_q <= sum_q + SUM_W'(elap_q);
			end
			if (cmd.drop || cmd.force_drop) begin
				sum_q  <= sum_q - SUM_W'(rd_elap_q);
				tail_q <= inc(tail_q);
			end
			if (cmd.force_drop) begin
				ovf_q <= 1'b1;
			end
			if (cmd.adv_head) begin
				head_q <= head_nx;
			end
		end
	end

	// restoring divider, one quotient bit a cycle
	assign rem_sh = {rem_q[AW:0], num_q[QW-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			it_q       <= '0;
		end else if (cmd.div_start) begin
			div_busy_q <= (cnt_full != '0);
			it_q       <= IW'(QW);
		end else if (div_busy_q) begin
			it_q <= it_q - 1'b1;
			if (it_q == IW'(1)) begin
				div_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			num_q <= {sum_q, 8'd0};
			den_q <= cnt_full;
			rem_q <= '0;
			quo_q <= '0;
		end else if (div_busy_q) begin
			num_q <= {num_q[QW-2:0], 1'b0};
			rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	always_comb begin
		if (cnt_full == '0) begin
			mean_o = '0;
			last_o = '0;
		end else begin
			mean_o = (quo_q[QW-1:MEAN_W] != '0) ? '1 : quo_q[MEAN_W-1:0];
			last_o = last_q;
		end
		if (cnt_full > (AW+1)'(1023)) begin
			cnt_o = '1;
		end else begin
			cnt_o = CNT_W'(cnt_full);
		end
		sum_o = sum_q;
		ovf_o = ovf_q;
	end

endmodule

// ----- design/time_window_sample_averager.sv -----
// top level of the time window sample averager
// uses twsa_pkg, twsa_ctrl and twsa_dpath
//
// channel  | handshake                  | payload
// ---------+----------------------------+-----------------------------------------
// in       | in_valid / in_stall        | operation, now_time, start_time, elapsed
// out      | out_valid / out_stall      | entry_count, window_sum, last_elapsed,
//          |                            | mean_fixed, overflow
// cfg      | cfg_valid / cfg_ready      | cfg_data (max_age)
//
// one item at a time; a query culls expired tail samples, then reads the newest
// sample from the registered ring and runs the 50-step serial divider for the mean
// a record writes its sample and does the same; a full ring first culls from the tail
// arst_n clears indexes, sum, max_age to its default and all handshake state
// out_stall holds the result register; the next result waits behind it
module time_window_sample_averager import twsa_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              operation,
	input  logic [TIME_W-1:0] now_time,
	input  logic [TIME_W-1:0] start_time,
	input  logic [ELAP_W-1:0] elapsed,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CNT_W-1:0]  entry_count,
	output logic [SUM_W-1:0]  window_sum,
	output logic [ELAP_W-1:0] last_elapsed,
	output logic [MEAN_W-1:0] mean_fixed,
	output logic              overflow,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [31:0]       cfg_data
);

	cmd_t              cmd;
	stat_t             st;
	logic [31:0]       max_age_q;
	logic [CNT_W-1:0]  cnt_w;
	logic [SUM_W-1:0]  sum_w;
	logic [ELAP_W-1:0] last_w;
	logic [MEAN_W-1:0] mean_w;
	logic              ovf_w;
	logic              out_busy;

	// config register always takes a transfer
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q <= MAX_AGE_RESET;
		end else if (cfg_valid) begin
			max_age_q <= cfg_data;
		end
	end

	// result register is busy while its transfer is still pending
	assign out_busy = out_valid && out_stall;

	twsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_busy (out_busy),
		.st       (st),
		.cmd      (cmd)
	);

	twsa_dpath #(.DEPTH(DEPTH)) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.operation  (operation),
		.now_time   (now_time),
		.start_time (start_time),
		.elapsed    (elapsed),
		.max_age_q  (max_age_q),
		.cnt_o      (cnt_w),
		.sum_o      (sum_w),
		.last_o     (last_w),
		.mean_o     (mean_w),
		.ovf_o      (ovf_w)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_set) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_set) begin
			entry_count  <= cnt_w;
			window_sum   <= sum_w;
			last_elapsed <= last_w;
			mean_fixed   <= mean_w;
			overflow     <= ovf_w;
		end
	end

endmodule

// ----- sim/tb.sv -----
// testbench for the time window sample averager: directed and random record/query transfers
// checked against a scoreboard model of the ring; depends on twsa_pkg and the rtl
`timescale 1ns / 100ps

module tb;
	import twsa_pkg::*;

	localparam int RING      = DEPTH_DEF;
	localparam int CYC_LIMIT = 3000000;

	// one expected result
	typedef struct {
		logic [CNT_W-1:0]  cnt;
		logic [SUM_W-1:0]  sum;
		logic [ELAP_W-1:0] last;
		logic [MEAN_W-1:0] mean;
		logic              ovf;
	} window_stats_t;

	// window model plus queue of expected stats
	class window_board;
		logic [TIME_W-1:0] smp_start [RING];
		logic [ELAP_W-1:0] smp_elap [RING];
		int                head, tail;
		logic [SUM_W-1:0]  sum;
		logic [31:0]       max_age;
		window_stats_t     stats_q[$];
		int                errors;

		function new();
			head = 0;
			tail = 0;
			sum = '0;
			max_age = MAX_AGE_RESET;
			errors = 0;
		endfunction

		function bit aged_out(int slot, logic [TIME_W-1:0] now);
			// a start after now is never expired
			if (now <= smp_start[slot])
				return 0;
			return (now - smp_start[slot]) > {16'd0, max_age};
		endfunction

		function void drop_oldest();
			sum = sum - {10'd0, smp_elap[tail]};
			tail = (tail + 1) % RING;
		endfunction

		function void cull(logic [TIME_W-1:0] now);
			while (tail != head && aged_out(tail, now))
				drop_oldest();
		endfunction

		function void note(logic op, logic [TIME_W-1:0] now, logic [TIME_W-1:0] st,
				logic [ELAP_W-1:0] el);
			window_stats_t       s;
			int                  nxt, cnt;
			logic [DIVN_W-1:0]   q;
			s.ovf = 0;
			if (op == OP_RECORD) begin
				nxt = (head + 1) % RING;
				sum = sum + {10'd0, el};
				smp_start[head] = st;
				smp_elap[head] = el;
				// full ring: cull, then force out the oldest if still full
				if (nxt == tail) begin
					cull(now);
					if (nxt == tail) begin
						drop_oldest();
						s.ovf = 1;
					end
				end
				head = nxt;
			end else begin
				cull(now);
			end
			cnt = (head + RING - tail) % RING;
			if (cnt == 0) begin
				s.last = '0;
				s.mean = '0;
			end else begin
				s.last = smp_elap[(head + RING - 1) % RING];
				q = {sum, 8'd0} / cnt;
				s.mean = (q > {{(DIVN_W-MEAN_W){1'b0}}, {MEAN_W{1'b1}}}) ?
					{MEAN_W{1'b1}} : q[MEAN_W-1:0];
			end
			s.cnt = (cnt > 1023) ? 10'd1023 : cnt[CNT_W-1:0];
			s.sum = sum;
			stats_q.push_back(s);
		endfunction

		function void check(window_stats_t got);
			window_stats_t e;
			if (stats_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result transfer cnt=%0d", got.cnt);
				return;
			end
			e = stats_q.pop_front();
			if (got.cnt !== e.cnt || got.sum !== e.sum || got.last !== e.last ||
					got.mean !== e.mean || got.ovf !== e.ovf) begin
				errors++;
				if (errors <= 10)
					$display("stats differ: exp cnt=%0d sum=%h last=%h mean=%h ovf=%b, got cnt=%0d sum=%h last=%h mean=%h ovf=%b",
						e.cnt, e.sum, e.last, e.mean, e.ovf,
						got.cnt, got.sum, got.last, got.mean, got.ovf);
			end
		endfunction

		function int pending();
			return stats_q.size();
		endfunction
	endclass

	logic              clk = 0;
	logic              arst_n = 0;
	logic              in_valid = 0;
	logic              in_stall;
	logic              operation = OP_RECORD;
	logic [TIME_W-1:0] now_time = '0;
	logic [TIME_W-1:0] start_time = '0;
	logic [ELAP_W-1:0] elapsed = '0;
	logic              out_valid;
	logic              out_stall = 0;
	logic [CNT_W-1:0]  entry_count;
	logic [SUM_W-1:0]  window_sum;
	logic [ELAP_W-1:0] last_elapsed;
	logic [MEAN_W-1:0] mean_fixed;
	logic              overflow;
	logic              cfg_valid = 0;
	logic              cfg_ready;
	logic [31:0]       cfg_data = '0;

	window_board       board;
	int                send_idle_pct, recv_idle_pct;
	int                cycles = 0;
	logic [TIME_W-1:0] clock_now;

	time_window_sample_averager DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .now_time(now_time),
		.start_time(start_time), .elapsed(elapsed),
		.out_valid(out_valid), .out_stall(out_stall),
		.entry_count(entry_count), .window_sum(window_sum),
		.last_elapsed(last_elapsed), .mean_fixed(mean_fixed),
		.overflow(overflow),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYC_LIMIT) begin
			$display("time_window_sample_averager: mismatch");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// result monitor: a transfer happens where valid is high and stall low
	always @(posedge clk) begin
		window_stats_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.cnt = entry_count;
			got.sum = window_sum;
			got.last = last_elapsed;
			got.mean = mean_fixed;
			got.ovf = overflow;
			board.check(got);
		end
	end

	// one input transfer; valid stays high into the next item unless a gap is drawn
	task automatic send(logic op, logic [TIME_W-1:0] now, logic [TIME_W-1:0] st,
			logic [ELAP_W-1:0] el);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1;
		operation <= op;
		now_time <= now;
		start_time <= st;
		elapsed <= el;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note(op, now, st, el);
	endtask

	// stop sending and wait until every expected result has arrived
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (board.pending() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_max_age(logic [31:0] v);
		drain();
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
		board.max_age = v;
		@(posedge clk);
	endtask

	function automatic logic [TIME_W-1:0] rand48();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[TIME_W-1:0];
	endfunction

	function automatic logic [ELAP_W-1:0] rand_elap();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return $urandom_range(1000);
			default: return $urandom();
		endcase
	endfunction

	// random item around a moving clock; some far jumps and future starts
	task automatic random_item();
		logic [TIME_W-1:0] st;
		int                r;
		if ($urandom_range(19) == 0)
			clock_now = rand48();
		else
			clock_now = clock_now + $urandom_range(3000);
		r = $urandom_range(9);
		if (r < 7)
			st = clock_now - $urandom_range(2000000);
		else if (r < 9)
			st = clock_now + $urandom_range(5000);
		else
			st = rand48();
		send(($urandom_range(3) == 0) ? OP_QUERY : OP_RECORD, clock_now, st, rand_elap());
	endtask

	// fill past the ring depth with fresh samples
	task automatic fill_ring(int n, int step);
		repeat (n) begin
			clock_now = clock_now + step;
			send(OP_RECORD, clock_now, clock_now, rand_elap());
		end
	endtask

	initial begin
		board = new();
		send_idle_pct = 15;
		recv_idle_pct = 86;
		clock_now = 48'd5000000;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty query, elapsed extremes, start after now, time extremes
		send(OP_QUERY, '0, '1, '1);
		send(OP_RECORD, '0, '0, '0);
		send(OP_RECORD, 48'd10, 48'd10, '1);
		send(OP_RECORD, 48'd20, 48'd900, 32'd77);
		send(OP_QUERY, 48'd100, '0, '0);
		send(OP_RECORD, '1, '1, '1);
		send(OP_RECORD, '1, '0, 32'd1);
		send(OP_QUERY, '1, '1, '1);
		// the cull stops at the future start left at the tail, so nothing ages out here
		send(OP_QUERY, 48'd1000000000, '0, '0);

		// pause the sender until the block has answered everything
		drain();

		set_max_age(32'd0);
		send(OP_RECORD, 48'd500, 48'd500, 32'd3);
		send(OP_QUERY, 48'd500, '0, '0);
		send(OP_QUERY, 48'd501, '0, '0);
		send(OP_RECORD, 48'd600, 48'd700, 32'd9);
		send(OP_QUERY, 48'd1000, '0, '0);
		set_max_age('1);
		send(OP_RECORD, '1, '0, '1);
		send(OP_QUERY, '1, '0, '0);
		send(OP_QUERY, '0, '0, '0);

		// random phases under the three idling profiles
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				send_idle_pct = 86;
				recv_idle_pct = 15;
			end else if (ph == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			set_max_age($urandom_range(1) ? $urandom() : $urandom_range(4000000));
			repeat (65) random_item();
			set_max_age(ph == 0 ? 32'd1000000 : $urandom_range(100000));
			repeat (65) random_item();
		end

		// full ring with nothing expired: overflow drops
		set_max_age('1);
		fill_ring(1100, 1);
		// expire the whole ring in one long cull
		set_max_age(32'd0);
		clock_now = clock_now + 100;
		send(OP_QUERY, clock_now, '0, '0);
		// full ring where records cull the old end
		set_max_age(32'd500);
		fill_ring(1100, 1);
		repeat (40) random_item();

		drain();
		repeat (100) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("time_window_sample_averager: match");
		else
			$display("time_window_sample_averager: mismatch");
		$finish;
	end

endmodule
